// ===== hw/rtl/dtts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtts_pkg
// Types, unit name tables and range constants for the duration text parser.
// ----------------------------------------------------------------------------
package dtts_pkg;

    // beat formats
    typedef struct packed {
        logic [7:0] ch;
        logic       is_end;
    } t_in;

    typedef struct packed {
        logic               ok;
        logic signed [63:0] seconds;
    } t_out;

    localparam int UNIT_COUNT = 21;
    localparam int WORD_MAX   = 7;
    localparam int NAME_W     = 8 * WORD_MAX;
    localparam int LEN_W      = 4;
    localparam int CLASS_COUNT = 7;
    localparam int CLASS_W    = 3;
    localparam int SECS_W     = 25;

    // names left-justified, first character in the top byte, zero padded
    localparam logic [NAME_W-1:0] UNIT_NAME [UNIT_COUNT] = '{
        {"s",       48'h0}, {"sec",     32'h0}, {"secs",    24'h0},
        {"second",   8'h0}, {"seconds"},
        {"m",       48'h0}, {"min",     32'h0}, {"mins",    24'h0},
        {"minute",   8'h0}, {"minutes"},
        {"h",       48'h0}, {"hour",    24'h0}, {"hours",   16'h0},
        {"day",     32'h0}, {"days",    24'h0},
        {"week",    24'h0}, {"weeks",   16'h0},
        {"month",   16'h0}, {"months",   8'h0},
        {"year",    24'h0}, {"years",   16'h0}
    };

    localparam logic [LEN_W-1:0] UNIT_LEN [UNIT_COUNT] = '{
        4'd1, 4'd3, 4'd4, 4'd6, 4'd7,
        4'd1, 4'd3, 4'd4, 4'd6, 4'd7,
        4'd1, 4'd4, 4'd5,
        4'd3, 4'd4,
        4'd4, 4'd5,
        4'd5, 4'd6,
        4'd4, 4'd5
    };

    // scale class of each name
    localparam logic [CLASS_W-1:0] UNIT_CLASS [UNIT_COUNT] = '{
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
        3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
        3'd2, 3'd2, 3'd2,
        3'd3, 3'd3,
        3'd4, 3'd4,
        3'd5, 3'd5,
        3'd6, 3'd6
    };

    // seconds per unit: second, minute, hour, day, week, month, year
    localparam logic [SECS_W-1:0] CLASS_SECS [CLASS_COUNT] = '{
        25'd1, 25'd60, 25'd3600, 25'd86400,
        25'd604800, 25'd2678400, 25'd31536000
    };

    // largest magnitude whose product still fits; same for either sign
    // except seconds, where the positive bound is checked separately
    localparam logic [63:0] CLASS_LIM [CLASS_COUNT] = '{
        64'h8000_0000_0000_0000,
        64'd153722867280912930,
        64'd2562047788015215,
        64'd106751991167300,
        64'd15250284452471,
        64'd3443612618300,
        64'd292471208677
    };

    // a further digit overflows above this magnitude
    localparam logic [63:0] DIGIT_LIM = 64'd922337203685477580;

endpackage

// ===== hw/rtl/duration_text_to_seconds.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// duration_text_to_seconds
// Parses a duration text, one character per beat and closed by an end beat,
// into a signed 64-bit count of seconds with a success flag.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                  payload
//  in       sink       i_in_valid / o_in_ready    i_in  (ch, is_end)
//  out      source     o_out_valid / i_out_ready  o_out (ok, seconds)
//
//  One beat per cycle each way unless stalled. Character beats update the parse state
//  in the cycle they are taken and produce nothing; an end beat's result passes
//  stage a (unit lookup), stage b (split 32x25 multiply) and the output register (add).
//  A stalled output holds up to three pending results before o_in_ready drops.
//  Reset is synchronous and leaves the parser waiting for a new text.
// ----------------------------------------------------------------------------
module duration_text_to_seconds (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  dtts_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output dtts_pkg::t_out o_out
);
    import dtts_pkg::*;

    localparam logic [2:0] PH_START  = 3'd0;
    localparam logic [2:0] PH_SIGNED = 3'd1;
    localparam logic [2:0] PH_DIGITS = 3'd2;
    localparam logic [2:0] PH_GAP    = 3'd3;
    localparam logic [2:0] PH_WORD   = 3'd4;
    localparam logic [2:0] PH_AFTER  = 3'd5;

    // parse state
    logic [2:0]            r_phase, n_phase;
    logic [63:0]           r_mag, n_mag;
    logic                  r_neg, n_neg;
    logic [UNIT_COUNT-1:0] r_cand, n_cand;
    logic [LEN_W-1:0]      r_len, n_len;
    logic                  r_failed, n_failed;

    // result pipeline
    logic              r_a_valid, r_a_ok;
    logic [63:0]       r_a_opnd;
    logic [SECS_W-1:0] r_a_secs;
    logic              r_b_valid, r_b_ok;
    logic [56:0]       r_b_lo;
    logic [31:0]       r_b_hi;
    logic              r_o_valid;
    t_out              r_o;

    logic ready_a, ready_b, ready_c;
    logic in_acc, end_acc, char_acc;

    // stage flow control
    assign ready_c  = !r_o_valid || i_out_ready;
    assign ready_b  = !r_b_valid || ready_c;
    assign ready_a  = !r_a_valid || ready_b;
    assign o_in_ready = ready_a;
    assign in_acc   = i_in_valid && ready_a;
    assign end_acc  = in_acc && i_in.is_end;
    assign char_acc = in_acc && !i_in.is_end;

    // character classes
    logic       is_ws, is_digit, is_sign;
    logic [3:0] digit;
    logic       dig_ovf;
    logic [63:0] mag_next;

    assign is_ws    = (i_in.ch == 8'h20) || (i_in.ch >= 8'h09 && i_in.ch <= 8'h0D);
    assign is_digit = (i_in.ch >= 8'h30) && (i_in.ch <= 8'h39);
    assign is_sign  = (i_in.ch == 8'h2B) || (i_in.ch == 8'h2D);
    assign digit    = i_in.ch[3:0];
    assign dig_ovf  = (r_mag > DIGIT_LIM) || (r_mag == DIGIT_LIM && digit == 4'd9);
    assign mag_next = {r_mag[60:0], 3'b000} + {r_mag[62:0], 1'b0} + {60'd0, digit};

    // unit word character: drop names that differ at this position
    logic [UNIT_COUNT-1:0] word_cand;
    logic [LEN_W-1:0]      word_len;
    logic [NAME_W-1:0]     name_sh;

    always_comb begin
        word_cand = r_cand;
        word_len  = r_len + 4'd1;
        name_sh   = '0;
        if (r_len >= LEN_W'(WORD_MAX)) begin
            word_cand = '0;
            word_len  = LEN_W'(WORD_MAX + 1);
        end else begin
            for (int i = 0; i < UNIT_COUNT; i++) begin
                name_sh = UNIT_NAME[i] << {r_len[2:0], 3'b000};
                if (name_sh[NAME_W-1 -: 8] != i_in.ch) begin
                    word_cand[i] = 1'b0;
                end
            end
        end
    end

    // parse state next value
    always_comb begin
        n_phase  = r_phase;
        n_mag    = r_mag;
        n_neg    = r_neg;
        n_cand   = r_cand;
        n_len    = r_len;
        n_failed = r_failed;
        if (end_acc) begin
            n_phase  = PH_START;
            n_mag    = '0;
            n_neg    = 1'b0;
            n_cand   = '1;
            n_len    = '0;
            n_failed = 1'b0;
        end else if (char_acc && !r_failed) begin
            case (r_phase)
                PH_START: begin
                    if (is_ws) begin
                        n_phase = r_phase;
                    end else if (is_sign) begin
                        n_neg   = (i_in.ch == 8'h2D);
                        n_phase = PH_SIGNED;
                    end else if (is_digit) begin
                        if (dig_ovf) n_failed = 1'b1;
                        else         n_mag    = mag_next;
                        n_phase = PH_DIGITS;
                    end else begin
                        n_failed = 1'b1;
                    end
                end
                PH_SIGNED: begin
                    if (is_digit) begin
                        if (dig_ovf) n_failed = 1'b1;
                        else         n_mag    = mag_next;
                        n_phase = PH_DIGITS;
                    end else begin
                        n_failed = 1'b1;
                    end
                end
                PH_DIGITS: begin
                    if (is_digit) begin
                        if (dig_ovf) n_failed = 1'b1;
                        else         n_mag    = mag_next;
                    end else if (is_ws) begin
                        n_phase = PH_GAP;
                    end else begin
                        n_cand  = word_cand;
                        n_len   = word_len;
                        n_phase = PH_WORD;
                    end
                end
                PH_GAP: begin
                    if (!is_ws) begin
                        n_cand  = word_cand;
                        n_len   = word_len;
                        n_phase = PH_WORD;
                    end
                end
                PH_WORD: begin
                    if (is_ws) begin
                        n_phase = PH_AFTER;
                    end else begin
                        n_cand = word_cand;
                        n_len  = word_len;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_START;
            r_mag    <= '0;
            r_neg    <= 1'b0;
            r_cand   <= '1;
            r_len    <= '0;
            r_failed <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_mag    <= n_mag;
            r_neg    <= n_neg;
            r_cand   <= n_cand;
            r_len    <= n_len;
            r_failed <= n_failed;
        end
    end

    // end beat: pick the first full-length match and check the range
    logic [UNIT_COUNT-1:0] hit;
    logic                  found;
    logic [CLASS_W-1:0]    cls;
    logic                  pre_fail, in_word, end_ok;
    logic [63:0]           opnd;

    always_comb begin
        found = 1'b0;
        cls   = '0;
        for (int i = 0; i < UNIT_COUNT; i++) begin
            hit[i] = r_cand[i] && (UNIT_LEN[i] == r_len);
        end
        for (int i = UNIT_COUNT - 1; i >= 0; i--) begin
            if (hit[i]) begin
                found = 1'b1;
                cls   = UNIT_CLASS[i];
            end
        end
    end

    assign pre_fail = r_failed || (!r_neg && r_mag[63]);
    assign in_word  = (r_phase == PH_WORD) || (r_phase == PH_AFTER);
    assign end_ok   = !pre_fail && in_word && found && (r_mag <= CLASS_LIM[cls]);
    // negate before the multiply; the low 64 product bits come out signed
    assign opnd     = r_neg ? (64'd0 - r_mag) : r_mag;

    // stage a: operand and scale
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (ready_a) begin
            r_a_valid <= end_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (end_acc) begin
            r_a_ok   <= end_ok;
            r_a_opnd <= opnd;
            r_a_secs <= CLASS_SECS[cls];
        end
    end

    // stage b: two partial products, only the low half of the upper one counts
    logic [56:0] prod_lo;
    logic [31:0] prod_hi;

    assign prod_lo = {25'd0, r_a_opnd[31:0]} * {32'd0, r_a_secs};
    assign prod_hi = 32'(r_a_opnd[63:32] * {7'd0, r_a_secs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (ready_b) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_b && r_a_valid) begin
            r_b_ok <= r_a_ok;
            r_b_lo <= prod_lo;
            r_b_hi <= prod_hi;
        end
    end

    // output register: combine partials, failure reads as -1
    t_out n_o;

    always_comb begin
        n_o.ok      = r_b_ok;
        n_o.seconds = r_b_ok ? ({7'd0, r_b_lo} + {r_b_hi, 32'd0}) : '1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (ready_c) begin
            r_o_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_c && r_b_valid) begin
            r_o <= n_o;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out       = r_o;

endmodule

// ===== hw/rtl/dtts_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtts_chk
// Port-level checks for the duration text parser, bound to its top level.
// ----------------------------------------------------------------------------
module dtts_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input dtts_pkg::t_in  i_in,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input dtts_pkg::t_out o_out
);
    import dtts_pkg::*;

    // a stalled result beat stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // a stalled result beat keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out))
        else $error("result payload changed while stalled");

    // failure always reads as minus one
    a_fail_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.ok |-> o_out.seconds == 64'hFFFF_FFFF_FFFF_FFFF)
        else $error("failed result not minus one");

    // with no result waiting the pipeline cannot be full
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    // reset leaves no result behind
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind duration_text_to_seconds dtts_chk u_dtts_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

// ===== sim/duration_parse_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// duration_parse_checker
// Watches both channels of the duration text parser. Keeps its own copy of
// the parse state, works out the result of every end beat and compares each
// output beat, field by field, with the oldest result still due.
// ----------------------------------------------------------------------------
module duration_parse_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_ready,
    input  dtts_pkg::t_in  i_in,
    input  logic           i_out_valid,
    input  logic           i_out_ready,
    input  dtts_pkg::t_out i_out,
    output int             o_errors,
    output int             o_pending,
    output int             o_results,
    output int             o_ok_count
);
    import dtts_pkg::*;

    typedef enum logic [2:0] {
        SEEK_NUMBER,
        AFTER_SIGN,
        IN_DIGITS,
        IN_GAP,
        IN_WORD,
        PAST_WORD
    } t_parse_state;

    localparam int          NUM_UNITS   = 21;
    localparam int          WORD_LIMIT  = 7;
    localparam logic [20:0] EVERY_UNIT  = 21'h1f_ffff;
    localparam logic [63:0] POS_MAX     = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] NEG_MAX     = 64'h8000_0000_0000_0000;
    localparam logic [63:0] TENTH_MAX   = 64'd922337203685477580;
    localparam logic [63:0] SECS_SECOND = 64'd1;
    localparam logic [63:0] SECS_MINUTE = 64'd60;
    localparam logic [63:0] SECS_HOUR   = 64'd3600;
    localparam logic [63:0] SECS_DAY    = 64'd86400;
    localparam logic [63:0] SECS_WEEK   = 64'd604800;
    localparam logic [63:0] SECS_MONTH  = 64'd2678400;
    localparam logic [63:0] SECS_YEAR   = 64'd31536000;
    localparam logic [7:0]  CH_TAB      = 8'h09;
    localparam logic [7:0]  CH_CR       = 8'h0d;
    localparam logic [7:0]  CH_SPACE    = 8'h20;
    localparam logic [7:0]  CH_PLUS     = 8'h2b;
    localparam logic [7:0]  CH_MINUS    = 8'h2d;
    localparam logic [7:0]  CH_ZERO     = 8'h30;
    localparam logic [7:0]  CH_NINE     = 8'h39;

    // parse state of the text in flight
    t_parse_state pstate;
    logic [63:0]  num_mag;
    logic         num_neg;
    logic [20:0]  unit_live;
    int           word_len;
    logic         text_dead;

    t_out seconds_due [$];
    int   err_count;
    int   result_count;
    int   ok_total;

    function automatic string unit_word(input int idx);
        case (idx)
            0:       return "s";
            1:       return "sec";
            2:       return "secs";
            3:       return "second";
            4:       return "seconds";
            5:       return "m";
            6:       return "min";
            7:       return "mins";
            8:       return "minute";
            9:       return "minutes";
            10:      return "h";
            11:      return "hour";
            12:      return "hours";
            13:      return "day";
            14:      return "days";
            15:      return "week";
            16:      return "weeks";
            17:      return "month";
            18:      return "months";
            19:      return "year";
            default: return "years";
        endcase
    endfunction

    function automatic logic [63:0] unit_scale(input int idx);
        if (idx < 5)  return SECS_SECOND;
        if (idx < 10) return SECS_MINUTE;
        if (idx < 13) return SECS_HOUR;
        if (idx < 15) return SECS_DAY;
        if (idx < 17) return SECS_WEEK;
        if (idx < 19) return SECS_MONTH;
        return SECS_YEAR;
    endfunction

    // names read as zero past their last character
    function automatic logic [7:0] name_byte(input string w, input int k);
        if (k < w.len()) return w[k];
        return 8'h00;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    task automatic clear_parse();
        pstate    = SEEK_NUMBER;
        num_mag   = '0;
        num_neg   = 1'b0;
        unit_live = EVERY_UNIT;
        word_len  = 0;
        text_dead = 1'b0;
    endtask

    // one more decimal digit, failing instead of wrapping
    task automatic push_digit(input logic [7:0] d);
        if (num_mag > TENTH_MAX || (num_mag == TENTH_MAX && d > 8'd8)) begin
            text_dead = 1'b1;
        end else begin
            num_mag = num_mag * 64'd10 + {56'd0, d};
        end
    endtask

    // narrow the set of unit names still matching the word
    task automatic add_letter(input logic [7:0] c);
        string w;
        if (word_len >= WORD_LIMIT) begin
            unit_live = '0;
            word_len  = WORD_LIMIT + 1;
        end else begin
            for (int i = 0; i < NUM_UNITS; i++) begin
                w = unit_word(i);
                if (name_byte(w, word_len) != c) unit_live[i] = 1'b0;
            end
            word_len++;
        end
    endtask

    task automatic take_char(input logic [7:0] c);
        if (!text_dead) begin
            case (pstate)
                SEEK_NUMBER: begin
                    if (c == CH_PLUS || c == CH_MINUS) begin
                        num_neg = (c == CH_MINUS);
                        pstate  = AFTER_SIGN;
                    end else if (is_digit(c)) begin
                        push_digit(c - CH_ZERO);
                        pstate = IN_DIGITS;
                    end else if (!is_blank(c)) begin
                        text_dead = 1'b1;
                    end
                end
                AFTER_SIGN: begin
                    if (is_digit(c)) begin
                        push_digit(c - CH_ZERO);
                        pstate = IN_DIGITS;
                    end else begin
                        text_dead = 1'b1;
                    end
                end
                IN_DIGITS: begin
                    if (is_digit(c)) begin
                        push_digit(c - CH_ZERO);
                    end else if (is_blank(c)) begin
                        pstate = IN_GAP;
                    end else begin
                        add_letter(c);
                        pstate = IN_WORD;
                    end
                end
                IN_GAP: begin
                    if (!is_blank(c)) begin
                        add_letter(c);
                        pstate = IN_WORD;
                    end
                end
                IN_WORD: begin
                    if (is_blank(c)) pstate = PAST_WORD;
                    else add_letter(c);
                end
                default: ;
            endcase
        end
    endtask

    // result of an end beat; first live name of the right length decides
    task automatic finish_text(output t_out res);
        string       w;
        logic [63:0] scale;
        logic [63:0] lim;
        logic [63:0] prod;
        logic        found;
        res.ok      = 1'b0;
        res.seconds = '1;
        found       = 1'b0;
        if (!text_dead && !num_neg && num_mag > POS_MAX) text_dead = 1'b1;
        if (!text_dead && (pstate == IN_WORD || pstate == PAST_WORD)) begin
            for (int i = 0; i < NUM_UNITS; i++) begin
                w = unit_word(i);
                if (!found && unit_live[i] && w.len() == word_len) begin
                    found = 1'b1;
                    scale = unit_scale(i);
                    lim   = num_neg ? NEG_MAX / scale : POS_MAX / scale;
                    if (num_mag <= lim) begin
                        prod        = num_mag * scale;
                        res.ok      = 1'b1;
                        res.seconds = num_neg ? 64'd0 - prod : prod;
                    end
                end
            end
        end
        clear_parse();
    endtask

    // follow both channels at every edge
    always @(posedge i_clk) begin : watch
        t_out due;
        t_out fresh;
        if (!i_rst_n) begin
            clear_parse();
            seconds_due.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                if (i_in.is_end) begin
                    finish_text(fresh);
                    seconds_due.push_back(fresh);
                    if (fresh.ok) ok_total++;
                end else begin
                    take_char(i_in.ch);
                end
            end
            if (i_out_valid && i_out_ready) begin
                result_count++;
                if (seconds_due.size() == 0) begin
                    $error("result beat with nothing due: ok %0d seconds %0d",
                           i_out.ok, i_out.seconds);
                    err_count++;
                end else begin
                    due = seconds_due.pop_front();
                    if (i_out.ok !== due.ok) begin
                        $error("ok mismatch: expected %0d, actual %0d", due.ok, i_out.ok);
                        err_count++;
                    end
                    if (i_out.seconds !== due.seconds) begin
                        $error("seconds mismatch: expected %0d, actual %0d",
                               due.seconds, i_out.seconds);
                        err_count++;
                    end
                end
            end
        end
        o_pending  <= seconds_due.size();
        o_errors   <= err_count;
        o_results  <= result_count;
        o_ok_count <= ok_total;
    end

endmodule

// ===== sim/duration_text_to_seconds_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// duration_text_to_seconds_tb
// Feeds duration texts into the parser one character beat at a time, closed
// by an end beat: a handful of hand-picked edge cases, then random texts,
// mostly well-formed with random numbers and unit words, some broken or pure
// noise. Both sides idle at random, the output is held off for a long
// stretch once, and the checker beside the block judges every result.
// ----------------------------------------------------------------------------
module duration_text_to_seconds_tb;
    import dtts_pkg::*;

    localparam int          RANDOM_BEATS = 150;
    localparam int          HOLD_CYCLES  = 300;
    localparam logic [63:0] POS_MAX      = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] NEG_MAX      = 64'h8000_0000_0000_0000;
    localparam logic [63:0] SECS_SECOND  = 64'd1;
    localparam logic [63:0] SECS_MINUTE  = 64'd60;
    localparam logic [63:0] SECS_HOUR    = 64'd3600;
    localparam logic [63:0] SECS_DAY     = 64'd86400;
    localparam logic [63:0] SECS_WEEK    = 64'd604800;
    localparam logic [63:0] SECS_MONTH   = 64'd2678400;
    localparam logic [63:0] SECS_YEAR    = 64'd31536000;
    localparam logic [7:0]  CH_NUL       = 8'h00;
    localparam logic [7:0]  CH_TAB       = 8'h09;
    localparam logic [7:0]  CH_LF        = 8'h0a;
    localparam logic [7:0]  CH_VT        = 8'h0b;
    localparam logic [7:0]  CH_FF        = 8'h0c;
    localparam logic [7:0]  CH_CR        = 8'h0d;
    localparam logic [7:0]  CH_SPACE     = 8'h20;
    localparam logic [7:0]  CH_PLUS      = 8'h2b;
    localparam logic [7:0]  CH_MINUS     = 8'h2d;
    localparam logic [7:0]  CH_LOWER_A   = 8'h61;
    localparam logic [7:0]  CH_TOP       = 8'hff;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_ready;
    t_in  in_beat   = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out out_beat;

    int error_count;
    int pending;
    int result_count;
    int ok_count;

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_trigger   = 1'b0;
    logic hold_seen      = 1'b0;
    int   hold_left      = 0;
    int   beat_count     = 0;
    int   text_count     = 0;

    logic [7:0] text_buf [$];

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    duration_text_to_seconds dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_beat)
    );

    duration_parse_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in        (in_beat),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out       (out_beat),
        .o_errors    (error_count),
        .o_pending   (pending),
        .o_results   (result_count),
        .o_ok_count  (ok_count)
    );

    // receiver: random stalls, or a long hold-off when one is requested
    always @(posedge clk) begin
        if (hold_trigger != hold_seen) begin
            hold_seen <= hold_trigger;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // run limit
    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic string unit_word(input int idx);
        case (idx)
            0:       return "s";
            1:       return "sec";
            2:       return "secs";
            3:       return "second";
            4:       return "seconds";
            5:       return "m";
            6:       return "min";
            7:       return "mins";
            8:       return "minute";
            9:       return "minutes";
            10:      return "h";
            11:      return "hour";
            12:      return "hours";
            13:      return "day";
            14:      return "days";
            15:      return "week";
            16:      return "weeks";
            17:      return "month";
            18:      return "months";
            19:      return "year";
            default: return "years";
        endcase
    endfunction

    function automatic logic [63:0] unit_scale(input int idx);
        if (idx < 5)  return SECS_SECOND;
        if (idx < 10) return SECS_MINUTE;
        if (idx < 13) return SECS_HOUR;
        if (idx < 15) return SECS_DAY;
        if (idx < 17) return SECS_WEEK;
        if (idx < 19) return SECS_MONTH;
        return SECS_YEAR;
    endfunction

    function automatic logic [7:0] rand_blank();
        int pick;
        pick = $urandom_range(5);
        if (pick == 5) return CH_SPACE;
        return CH_TAB + 8'(pick);
    endfunction

    function automatic logic [7:0] rand_letter();
        return CH_LOWER_A + 8'($urandom_range(25));
    endfunction

    task automatic add_byte(input logic [7:0] b);
        text_buf.push_back(b);
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    endtask

    // one beat, with a random gap in front; returns at the accepting edge
    task automatic put_beat(input logic [7:0] c, input logic e);
        t_in beat;
        beat.ch     = c;
        beat.is_end = e;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= beat;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        beat_count++;
    endtask

    task automatic send_text();
        foreach (text_buf[k]) put_beat(text_buf[k], 1'b0);
        put_beat(8'($urandom_range(255)), 1'b1);
        text_count++;
        text_buf.delete();
    endtask

    task automatic say(input string s);
        add_str(s);
        send_text();
    endtask

    // sender waits until every result due has come out
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // number, optional sign and blanks, unit word sometimes mangled
    task automatic make_wellformed();
        int          idx;
        logic [63:0] mag;
        logic [63:0] scale;
        string       w;
        repeat ($urandom_range(2)) add_byte(rand_blank());
        case ($urandom_range(3))
            0:       add_byte(CH_PLUS);
            1:       add_byte(CH_MINUS);
            default: ;
        endcase
        idx   = $urandom_range(20);
        scale = unit_scale(idx);
        case ($urandom_range(4))
            0:       mag = 64'($urandom_range(9));
            1:       mag = 64'($urandom_range(99999));
            2:       mag = {$urandom, $urandom};
            3:       mag = POS_MAX / scale + 64'($urandom_range(2)) - 64'd1;
            default: mag = NEG_MAX / scale + 64'($urandom_range(1));
        endcase
        if ($urandom_range(9) == 0) add_str("00");
        add_str($sformatf("%0d", mag));
        repeat ($urandom_range(2)) add_byte(rand_blank());
        w = unit_word(idx);
        case ($urandom_range(9))
            0:       w = w.toupper();
            1:       w = {w, "s"};
            2:       if (w.len() > 1) w = w.substr(0, w.len() - 2);
            3:       w[0] = rand_letter();
            default: ;
        endcase
        add_str(w);
        if ($urandom_range(3) == 0) begin
            add_byte(rand_blank());
            repeat ($urandom_range(4)) add_byte(8'($urandom_range(255)));
        end
    endtask

    // texts that go wrong at a chosen point
    task automatic make_broken();
        case ($urandom_range(3))
            0: begin
                add_byte($urandom_range(1) ? CH_PLUS : CH_MINUS);
                add_byte(8'($urandom_range(255)));
                add_str("s");
            end
            1: begin
                add_str($sformatf("%0d", $urandom));
                if ($urandom_range(1)) add_byte(rand_blank());
            end
            2: begin
                add_str($sformatf("%0d ", $urandom_range(999)));
                repeat ($urandom_range(10, 7)) add_byte(rand_letter());
            end
            default: begin
                add_byte(rand_letter());
                add_str("12 min");
            end
        endcase
    endtask

    task automatic run_random(input int beats);
        int stop;
        int pick;
        stop = beat_count + beats;
        while (beat_count < stop) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
                make_wellformed();
            end else if (pick < 88) begin
                make_broken();
            end else begin
                repeat ($urandom_range(8)) add_byte(8'($urandom_range(255)));
            end
            send_text();
        end
    endtask

    initial begin : stimulus
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // edge cases, under sparse sender gaps and heavy output stalls
        send_idle_pct = 10;
        recv_stall_pct <= 61;
        say("5s");
        say(" -0 sec");
        say("+12 minutes  x!");
        say("9223372036854775807s");
        say("-9223372036854775808 seconds");
        say("9223372036854775808 s");
        say("-92233720368547758090 s");
        say("- 5 s");
        say("");
        say("42 ");
        say("3 secondss");
        say("106751991167301 days");
        say("-292471208677 years");
        say("7 Hours");
        say("1 mo");
        say("3 months");
        // every blank character before the number, a carriage return after it
        add_byte(CH_TAB);
        add_byte(CH_LF);
        add_byte(CH_VT);
        add_byte(CH_FF);
        add_byte(CH_CR);
        add_str("7");
        add_byte(CH_CR);
        add_str("weeks");
        add_byte(CH_TAB);
        add_str("junk");
        send_text();
        // all-ones and all-zeros characters inside the word
        add_str("1 h");
        add_byte(CH_TOP);
        send_text();
        add_str("2");
        add_byte(CH_NUL);
        send_text();
        // bytes after a failure are ignored
        add_str("x");
        add_byte(CH_TOP);
        add_str("5 s");
        send_text();
        drain();

        run_random(RANDOM_BEATS / 3);
        drain();

        // heavy sender gaps, light output stalls
        send_idle_pct = 61;
        recv_stall_pct <= 10;
        run_random(RANDOM_BEATS / 3);
        drain();

        // output held off while short texts come back to back
        send_idle_pct = 0;
        recv_stall_pct <= 0;
        hold_trigger <= ~hold_trigger;
        repeat (40) say("1s");
        run_random(RANDOM_BEATS / 3);
        drain();
        repeat (10) @(posedge clk);

        $display("%0d texts in %0d beats, %0d results checked, %0d of them a valid duration",
                 text_count, beat_count, result_count, ok_count);
        $display("edge cases, random well-formed and broken texts, long output hold-off");
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
